[design/assert_macros.svh]
// Assertion macros used by the top-level RTL file to check its own behavior.
// Depends on nothing; include by bare file name inside a module body.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

[design/ccr_pkg.sv]
// Shared constants, types and helper functions for the component counter.
// No dependencies; imported by ccr_if, ccr_pick and the top level.
package ccr_pkg;

  localparam int MAX_CITIES = 1024;
  localparam int IDX_W      = $clog2(MAX_CITIES);
  localparam int LVL_W      = IDX_W + 1;
  localparam int CITY_W     = 11;
  localparam int ROADS_W    = 10;
  localparam int LANE       = 32;
  localparam int LANE_W     = $clog2(LANE);
  localparam int GROUPS     = MAX_CITIES / LANE;
  localparam int GRP_W      = $clog2(GROUPS);
  localparam logic [CITY_W-1:0] NODE_RESET = CITY_W'(1024);
  localparam logic [ROADS_W-1:0] ROADS_MAX = '1;

  typedef logic [MAX_CITIES-1:0] row_t;

  typedef struct packed {
    logic             found;
    logic [IDX_W-1:0] idx;
  } pick_t;

  typedef enum logic [12:0] {
    S_CLEAR  = 13'b0000000000001,
    S_IDLE   = 13'b0000000000010,
    S_ADD_RA = 13'b0000000000100,
    S_ADD_WA = 13'b0000000001000,
    S_ADD_RB = 13'b0000000010000,
    S_ADD_WB = 13'b0000000100000,
    S_INIT   = 13'b0000001000000,
    S_SEEK   = 13'b0000010000000,
    S_PUSH   = 13'b0000100000000,
    S_POP    = 13'b0001000000000,
    S_POPW   = 13'b0010000000000,
    S_DONE   = 13'b0100000000000,
    S_SPARE  = 13'b1000000000000
  } state_t;

  // Lowest set bit of one lane.
  function automatic logic [LANE_W-1:0] ffs_lane(input logic [LANE-1:0] v);
    logic [LANE_W-1:0] r;
    r = '0;
    for (int i = LANE - 1; i >= 0; i--) begin
      if (v[i]) r = LANE_W'(i);
    end
    return r;
  endfunction

endpackage

[design/ccr_if.sv]
// Valid/ready channel interfaces for requests and responses.
// Depends on ccr_pkg for field widths.
interface ccr_req_if;
  import ccr_pkg::*;
  logic              valid;
  logic              ready;
  logic              mode;
  logic [CITY_W-1:0] city_a;
  logic [CITY_W-1:0] city_b;
  modport source (output valid, mode, city_a, city_b, input ready);
  modport sink   (input valid, mode, city_a, city_b, output ready);
endinterface

interface ccr_rsp_if;
  import ccr_pkg::*;
  logic               valid;
  logic               ready;
  logic [ROADS_W-1:0] roads_needed;
  logic               bad_city;
  modport source (output valid, roads_needed, bad_city, input ready);
  modport sink   (input valid, roads_needed, bad_city, output ready);
endinterface

[design/ccr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ccr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

[design/ccr_pick.sv]
// Find-first-set over a full city row: lane flags, then lane and bit select.
// Depends on ccr_pkg.
module ccr_pick (
  input  ccr_pkg::row_t  vec,
  output ccr_pkg::pick_t pick
);
  import ccr_pkg::*;

  logic [GROUPS-1:0] any;
  logic [GRP_W-1:0]  grp;
  logic [LANE-1:0]   lane;

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      any[g] = |vec[g*LANE +: LANE];
    end
  end

  assign grp        = GRP_W'(ffs_lane(LANE'(any)));
  assign lane       = vec[grp*LANE +: LANE];
  assign pick.found = |any;
  assign pick.idx   = {grp, ffs_lane(lane)};
endmodule

[design/components_after_node_removal.sv]
// Top level: road map in RAM, depth-first walk with a stack RAM.
// Depends on ccr_pkg, ccr_if, ccr_ram, ccr_pick and assert_macros.svh.
//
//   channel | dir | handshake      | payload
//   req     | in  | valid/ready    | mode, city_a, city_b
//   rsp     | out | valid/ready    | roads_needed, bad_city
//   cfg     | in  | cfg_we         | cfg_wdata (node_count)
//
// After reset the road map is cleared one row a cycle, with req held not
// ready until every row is cleared. An add-road transaction makes two
// read-modify-write passes on the adjacency RAM. A query seeks each
// unvisited city as a component start, then pushes the unvisited neighbors
// of each row onto the stack and pops them in turn, reading each popped
// city's row. A bad city goes straight to the done state. The response
// register holds a result until taken while the next transaction is
// already accepted; a result that waits longer holds the block in its
// done state.
module components_after_node_removal (
  input  logic                          clk,
  input  logic                          rst,
  ccr_req_if.sink                       req,
  ccr_rsp_if.source                     rsp,
  input  logic                          cfg_we,
  input  logic [ccr_pkg::CITY_W-1:0]    cfg_wdata
);
  import ccr_pkg::*;
  `include "assert_macros.svh"

  state_t state, state_next;

  logic [CITY_W-1:0]  node_count;
  logic [CITY_W-1:0]  eff_n;
  logic [IDX_W-1:0]   clr_cnt;
  logic [IDX_W-1:0]   a_idx, b_idx;
  logic               res_bad;
  logic [ROADS_W-1:0] res_roads;
  row_t               visited;
  logic [LVL_W-1:0]   lvl;
  logic [LVL_W-1:0]   comp;

  // adjacency RAM ports
  logic             adj_we, adj_re;
  logic [IDX_W-1:0] adj_waddr, adj_raddr;
  row_t             adj_wdata, adj_rdata;
  // stack RAM ports
  logic             stk_we, stk_re;
  logic [IDX_W-1:0] stk_waddr, stk_raddr;
  logic [IDX_W-1:0] stk_wdata, stk_rdata;

  row_t  pick_vec;
  pick_t pick;

  logic a_ok, b_ok, out_free;

  ccr_ram #(.WIDTH(MAX_CITIES), .DEPTH(MAX_CITIES)) u_adj (
    .clk, .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
    .re(adj_re), .raddr(adj_raddr), .rdata(adj_rdata)
  );

  ccr_ram #(.WIDTH(IDX_W), .DEPTH(MAX_CITIES)) u_stack (
    .clk, .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .re(stk_re), .raddr(stk_raddr), .rdata(stk_rdata)
  );

  ccr_pick u_pick (.vec(pick_vec), .pick);

  // Saturate the count to the map size.
  assign eff_n = (node_count > CITY_W'(MAX_CITIES)) ? CITY_W'(MAX_CITIES) : node_count;
  assign a_ok  = (req.city_a != '0) && (req.city_a <= eff_n);
  assign b_ok  = (req.city_b != '0) && (req.city_b <= eff_n);

  assign req.ready = (state == S_IDLE);
  assign out_free  = !rsp.valid || rsp.ready;

  // Seek scans unvisited cities; push scans unvisited neighbors of the row.
  assign pick_vec = (state == S_PUSH) ? (adj_rdata & ~visited) : ~visited;

  always_comb begin
    state_next = state;
    adj_we     = 1'b0;
    adj_waddr  = a_idx;
    adj_wdata  = adj_rdata | (row_t'(1) << b_idx);
    adj_re     = 1'b0;
    adj_raddr  = a_idx;
    stk_we     = 1'b0;
    stk_waddr  = lvl[IDX_W-1:0];
    stk_wdata  = pick.idx;
    stk_re     = 1'b0;
    stk_raddr  = IDX_W'(lvl - LVL_W'(1));
    case (state)
      S_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_cnt;
        adj_wdata = '0;
        if (clr_cnt == IDX_W'(MAX_CITIES - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) begin
          if (!req.mode) state_next = (a_ok && b_ok) ? S_ADD_RA : S_DONE;
          else           state_next = a_ok ? S_INIT : S_DONE;
        end
      end
      S_ADD_RA: begin
        adj_re     = 1'b1;
        state_next = S_ADD_WA;
      end
      S_ADD_WA: begin
        adj_we     = 1'b1;
        state_next = S_ADD_RB;
      end
      S_ADD_RB: begin
        adj_re     = 1'b1;
        adj_raddr  = b_idx;
        state_next = S_ADD_WB;
      end
      S_ADD_WB: begin
        adj_we     = 1'b1;
        adj_waddr  = b_idx;
        adj_wdata  = adj_rdata | (row_t'(1) << a_idx);
        state_next = S_IDLE;
      end
      S_INIT: state_next = S_SEEK;
      S_SEEK: begin
        if (pick.found) begin
          adj_re     = 1'b1;
          adj_raddr  = pick.idx;
          state_next = S_PUSH;
        end else begin
          state_next = S_DONE;
        end
      end
      S_PUSH: begin
        if (pick.found) stk_we = 1'b1;
        else            state_next = S_POP;
      end
      S_POP: begin
        if (lvl == '0) begin
          state_next = S_SEEK;
        end else begin
          stk_re     = 1'b1;
          state_next = S_POPW;
        end
      end
      S_POPW: begin
        adj_re     = 1'b1;
        adj_raddr  = stk_rdata;
        state_next = S_PUSH;
      end
      S_DONE: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_cnt    <= '0;
      node_count <= NODE_RESET;
      rsp.valid  <= 1'b0;
      lvl        <= '0;
      comp       <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) node_count <= cfg_wdata;
      if (state == S_CLEAR) clr_cnt <= clr_cnt + IDX_W'(1);

      // Load a new response when done; otherwise drop the old one once taken.
      if (state == S_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready)              rsp.valid <= 1'b0;

      case (state)
        S_INIT: begin
          lvl  <= '0;
          comp <= '0;
        end
        S_SEEK: if (pick.found) comp <= comp + LVL_W'(1);
        S_PUSH: if (pick.found) lvl <= lvl + LVL_W'(1);
        S_POP:  if (lvl != '0) lvl <= lvl - LVL_W'(1);
        default: ;
      endcase
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && req.valid) begin
      a_idx   <= IDX_W'(req.city_a - CITY_W'(1));
      b_idx   <= IDX_W'(req.city_b - CITY_W'(1));
      res_bad <= req.mode ? !a_ok : !(a_ok && b_ok);
    end
    if (state == S_SEEK && !pick.found) begin
      res_roads <= (comp == '0) ? '0
                 : (comp > LVL_W'(ROADS_MAX)) ? ROADS_MAX
                 : ROADS_W'(comp - LVL_W'(1));
    end
    if (state == S_DONE && out_free) begin
      rsp.bad_city     <= res_bad;
      rsp.roads_needed <= res_bad ? '0 : res_roads;
    end
    // Mark cities beyond the count and the removed one as already visited.
    if (state == S_INIT) begin
      for (int i = 0; i < MAX_CITIES; i++) begin
        visited[i] <= (CITY_W'(i) >= eff_n) || (IDX_W'(i) == a_idx);
      end
    end
    if ((state == S_SEEK || state == S_PUSH) && pick.found) visited[pick.idx] <= 1'b1;
  end

  `CHK_NOW(a_clear_blocks, clk, rst, state == S_CLEAR, !req.ready)
  `CHK_NOW(a_push_fresh, clk, rst, state == S_PUSH && pick.found, !visited[pick.idx])
  `CHK_NOW(a_stack_bound, clk, rst, 1'b1, lvl <= LVL_W'(MAX_CITIES))
  `CHK_NOW(a_bad_zero, clk, rst, rsp.valid && rsp.bad_city, rsp.roads_needed == '0)
  `CHK_NEXT(a_done_loads, clk, rst, state == S_DONE && out_free, rsp.valid)
endmodule
